// ===== rtl/windowed_state_histogram_profiler_defines.svh =====
// ---------------------------------------------------------------------------
// Histogram profiler assertion macros
// Shared check macros for the profiler RTL; empty when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef WINDOWED_STATE_HISTOGRAM_PROFILER_DEFINES_SVH
`define WINDOWED_STATE_HISTOGRAM_PROFILER_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge out of reset
`define WSHP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("profiler check failed");

// Condition that must never be seen out of reset
`define WSHP_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("profiler forbidden condition seen");

`else

`define WSHP_ASSERT(lbl, prop)
`define WSHP_ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== rtl/wshp_pkg.sv =====
// ---------------------------------------------------------------------------
// Histogram profiler package
// Field widths, item and register codes, state and result types.
// ---------------------------------------------------------------------------
`default_nettype none

package wshp_pkg;

	// Default sizing
	localparam int DEF_MAX_OPERATORS = 64;
	localparam int DEF_COUNT_WIDTH   = 32;

	// Fixed field widths
	localparam int MODE_W  = 2;
	localparam int ID_W    = 6;
	localparam int OPC_W   = 7;
	localparam int FLIP_W  = 24;
	localparam int QUOT_W  = 7;
	localparam int REG_IDX_W = 1;

	// Item codes
	localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_OPERATOR_COUNT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FLIP_TICKS     = 1'b1;

	// Register reset values
	localparam logic [OPC_W-1:0]  RST_OPERATOR_COUNT = 7'd64;
	localparam logic [FLIP_W-1:0] RST_FLIP_TICKS     = 24'd1000;

	// Full share in percent
	localparam logic [QUOT_W-1:0] PERCENT_FULL = 7'd100;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REC_RD,
		ST_REC_WR,
		ST_SUM,
		ST_DIV,
		ST_OUT
	} wshp_state_t;

	// Divider result towards the controller
	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quotient;
	} wshp_div_res_t;

endpackage

`default_nettype wire

// ===== rtl/wshp_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module wshp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/wshp_div.sv =====
// ---------------------------------------------------------------------------
// Histogram profiler share divider
// Scales a bin by 100 with shift-adds, then divides by the operator sum
// one quotient bit per cycle (restoring division).
// ---------------------------------------------------------------------------
`default_nettype none

module wshp_div #(
	parameter int COUNT_WIDTH = 32,
	parameter int SUM_W       = 38
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [COUNT_WIDTH-1:0] bin,
	input  wire logic [SUM_W-1:0]       sum,
	output wshp_pkg::wshp_div_res_t     res
);

	import wshp_pkg::*;

	localparam int DIV_W  = SUM_W + QUOT_W;
	localparam int STEP_W = $clog2(QUOT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [DIV_W-1:0]  bin_ext_q;
	logic [QUOT_W-1:0] quot_q;
	logic [DIV_W-1:0]  bin_ext;

	assign bin_ext = DIV_W'(bin);

	// Sequence control: step 0 finishes the scaling, then one step per bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(QUOT_W)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: 100 = 64 + 32 + 4, divisor walks down from sum << 6
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= (bin_ext << 2) + (bin_ext << 5);
			bin_ext_q <= bin_ext;
			dvs_q     <= DIV_W'(sum) << (QUOT_W - 1);
			quot_q    <= '0;
		end else if (busy_q) begin
			if (step_q == '0) begin
				rem_q <= rem_q + (bin_ext_q << 6);
			end else begin
				if (rem_q >= dvs_q) begin
					rem_q  <= rem_q - dvs_q;
					quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
				end else begin
					quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
				end
				dvs_q <= dvs_q >> 1;
			end
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quot_q;

endmodule

`default_nettype wire

// ===== rtl/windowed_state_histogram_profiler.sv =====
// ---------------------------------------------------------------------------
// Windowed state histogram profiler.
// Input channel (in_valid / in_stall) carries one request per accept: mode
// record counts one sample into an operator bin or the system bin, mode
// tick advances the tick counter and clears every bin when it reaches
// flip_ticks, mode query returns one operator's share of all operator
// samples in whole percent. Only a query produces a result on the output
// channel (out_valid / out_stall), with status set for an index beyond the
// operator count in use. Configuration writes go over cfg_valid / cfg_ready
// and are taken at any time; cfg_ready is always high.
// Sequencing: a tick or a dropped record is done when it is accepted; a
// counted record reads its bin from memory, then writes it back. A query
// sums the bins of all operators in use, runs the bit-serial divider and
// then loads its result; an empty histogram or an out-of-range index skips
// the divider. One request is worked on at a time; in_stall is high while
// it runs. When the receiver stalls, a following query waits before its
// result is loaded.
// Reset clears all bins (by per-entry valid bits), the tick counter and the
// registers to their defaults.
// ---------------------------------------------------------------------------
`default_nettype none
`include "windowed_state_histogram_profiler_defines.svh"

module windowed_state_histogram_profiler #(
	parameter int MAX_OPERATORS = wshp_pkg::DEF_MAX_OPERATORS,
	parameter int COUNT_WIDTH   = wshp_pkg::DEF_COUNT_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration writes
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [wshp_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [wshp_pkg::FLIP_W-1:0]    cfg_data,
	// request channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [wshp_pkg::MODE_W-1:0]    mode,
	input  wire logic [wshp_pkg::ID_W-1:0]      operator_id,
	input  wire logic                           in_system,
	input  wire logic [wshp_pkg::ID_W-1:0]      query_index,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [wshp_pkg::QUOT_W-1:0]         cost_percent,
	output logic                                status
);

	import wshp_pkg::*;

	localparam int NBINS   = MAX_OPERATORS + 1;
	localparam int IDX_W   = $clog2(NBINS);
	localparam int SUM_W   = COUNT_WIDTH + $clog2(MAX_OPERATORS);
	localparam int N_CAP_I = (MAX_OPERATORS > (2 ** OPC_W - 1)) ? (2 ** OPC_W - 1)
		: MAX_OPERATORS;
	localparam logic [OPC_W-1:0] N_CAP   = OPC_W'(N_CAP_I);
	localparam logic [IDX_W-1:0] SYS_IDX = IDX_W'(MAX_OPERATORS);

	wshp_state_t state_q, state_nxt;

	logic [OPC_W-1:0]       op_count_q;
	logic [FLIP_W-1:0]      flip_ticks_q;
	logic [FLIP_W-1:0]      tick_q;
	logic [NBINS-1:0]       valid_q;
	logic [OPC_W-1:0]       n_use;
	logic                   accept;
	logic                   rec_hit;
	logic [IDX_W-1:0]       rec_idx;
	logic [IDX_W-1:0]       rec_idx_q;
	logic [ID_W-1:0]        query_q;
	logic                   q_oor;
	logic [OPC_W-1:0]       cnt_q;
	logic [OPC_W-1:0]       cnt_s1;
	logic                   pend_s1;
	logic [SUM_W-1:0]       sum_q;
	logic [COUNT_WIDTH-1:0] bin_q;
	logic [COUNT_WIDTH-1:0] rd_data;
	logic [COUNT_WIDTH-1:0] entry;
	logic [COUNT_WIDTH-1:0] cur_bin;
	logic [IDX_W-1:0]       rd_addr;
	logic                   wr_en;
	logic [COUNT_WIDTH-1:0] wr_data;
	logic [FLIP_W-1:0]      tick_nxt;
	logic [FLIP_W-1:0]      tick_limit;
	logic                   tick_flip;
	logic                   div_start;
	wshp_div_res_t          div_res;
	logic                   out_load;
	logic                   out_valid_q;
	logic [QUOT_W-1:0]      cost_q;
	logic                   status_q;
	logic [QUOT_W-1:0]      cost_nxt;

	// Clamp the operator count to 1..MAX_OPERATORS (at most 127)
	always_comb begin
		if (op_count_q == '0) begin
			n_use = OPC_W'(1);
		end else if (op_count_q > N_CAP) begin
			n_use = N_CAP;
		end else begin
			n_use = op_count_q;
		end
	end

	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Record target: system bin wins, unknown operators are dropped
	assign rec_hit = in_system || ({1'b0, operator_id} < n_use);
	assign rec_idx = in_system ? SYS_IDX : IDX_W'(operator_id);
	assign q_oor   = ({1'b0, query_q} >= n_use);

	// Tick counter and window flip
	assign tick_nxt   = tick_q + FLIP_W'(1);
	assign tick_limit = (flip_ticks_q == '0) ? FLIP_W'(1) : flip_ticks_q;
	assign tick_flip  = accept && (mode == MODE_TICK) && (tick_nxt >= tick_limit);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_count_q   <= RST_OPERATOR_COUNT;
			flip_ticks_q <= RST_FLIP_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OPERATOR_COUNT: op_count_q   <= cfg_data[OPC_W-1:0];
				REG_FLIP_TICKS:     flip_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and control
	always_comb begin
		state_nxt = state_q;
		in_stall  = (state_q != ST_IDLE);
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// idle never stalls, so a valid request is taken here
				if (in_valid) begin
					case (mode)
						MODE_RECORD: begin
							if (rec_hit) begin
								state_nxt = ST_REC_RD;
							end
						end
						MODE_QUERY: state_nxt = ST_SUM;
						default: ;
					endcase
				end
			end
			ST_REC_RD: state_nxt = ST_REC_WR;
			ST_REC_WR: state_nxt = ST_IDLE;
			ST_SUM: begin
				if ((cnt_q == n_use) && !pend_s1) begin
					if (q_oor || (sum_q == '0)) begin
						state_nxt = ST_OUT;
					end else begin
						div_start = 1'b1;
						state_nxt = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_res.done) begin
					state_nxt = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Tick counter and bin valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			valid_q <= '0;
		end else begin
			if (accept && (mode == MODE_TICK)) begin
				tick_q <= tick_flip ? '0 : tick_nxt;
			end
			if (tick_flip) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[rec_idx_q] <= 1'b1;
			end
		end
	end

	// Sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else if (state_q == ST_SUM) begin
			pend_s1 <= (cnt_q < n_use);
			if (cnt_q < n_use) begin
				cnt_q <= cnt_q + OPC_W'(1);
			end
		end else begin
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end
	end

	// Request fields, running sum and queried bin
	always_ff @(posedge clk) begin
		if (accept) begin
			rec_idx_q <= rec_idx;
			query_q   <= query_index;
			sum_q     <= '0;
			bin_q     <= '0;
		end else if (state_q == ST_SUM) begin
			cnt_s1 <= cnt_q;
			if (pend_s1) begin
				sum_q <= sum_q + SUM_W'(entry);
				if (cnt_s1 == {1'b0, query_q}) begin
					bin_q <= entry;
				end
			end
		end
	end

	// Bin memory access; an entry not yet written since the last clear reads 0
	assign rd_addr = (state_q == ST_SUM) ? IDX_W'(cnt_q) : rec_idx_q;
	assign entry   = valid_q[IDX_W'(cnt_s1)] ? rd_data : '0;
	assign cur_bin = valid_q[rec_idx_q] ? rd_data : '0;
	assign wr_en   = (state_q == ST_REC_WR) && (cur_bin != '1);
	assign wr_data = cur_bin + COUNT_WIDTH'(1);

	wshp_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (NBINS)
	) u_bins (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (rec_idx_q),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	wshp_div #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.SUM_W       (SUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.bin    (bin_q),
		.sum    (sum_q),
		.res    (div_res)
	);

	// Share in percent, capped, zero for empty or out-of-range queries
	always_comb begin
		if (q_oor || (sum_q == '0)) begin
			cost_nxt = '0;
		end else if (div_res.quotient > PERCENT_FULL) begin
			cost_nxt = PERCENT_FULL;
		end else begin
			cost_nxt = div_res.quotient;
		end
	end

	// Output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cost_q   <= cost_nxt;
			status_q <= q_oor;
		end
	end

	assign out_valid    = out_valid_q;
	assign cost_percent = cost_q;
	assign status       = status_q;

	// Checks
	`WSHP_ASSERT(a_cost_in_range, out_valid |-> (cost_percent <= PERCENT_FULL))
	`WSHP_ASSERT(a_oor_zero, (out_valid && status) |-> (cost_percent == '0))
	`WSHP_ASSERT(a_flip_clears, tick_flip |=> (valid_q == '0))
	`WSHP_ASSERT_NEVER(a_sweep_bound, (state_q == ST_SUM) && (cnt_q > n_use))

endmodule

`default_nettype wire
